/* rtl/cir_pkg.sv */
// package for the chunked image reassembly block
// holds packet constants, event codes and the result record type; no dependencies
`default_nettype none

package cir_pkg;

  // default sizing
  localparam int MAX_CHUNKS_DEFAULT  = 128;
  localparam int IMAGE_BYTES_DEFAULT = 2400;

  // packet type bytes and lengths
  localparam logic [7:0] KIND_IMAGE  = 8'h01;
  localparam logic [7:0] KIND_META   = 8'h02;
  localparam logic [7:0] TOTAL_LIMIT = 8'd128;
  localparam logic [7:0] META_LEN    = 8'd8;
  localparam logic [7:0] HEADER_LEN  = 8'd5;

  // header byte positions
  localparam logic [7:0] POS_CHUNK_LO = 8'd1;
  localparam logic [7:0] POS_CHUNK_HI = 8'd2;
  localparam logic [7:0] POS_TOTAL_LO = 8'd3;
  localparam logic [7:0] POS_TOTAL_HI = 8'd4;

  // chunk size after reset
  localparam logic [7:0] CHUNK_BYTES_RESET = 8'd200;

  // result queue depth
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    EV_WRITE    = 2'd0,
    EV_META     = 2'd1,
    EV_COMPLETE = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [11:0] write_addr;
    logic [7:0]  write_data;
    logic [15:0] mean_delta;
    logic [7:0]  peak_delta;
    logic [15:0] changed_count;
    logic [7:0]  grey_level;
    logic        sent_flag;
    logic [7:0]  total_chunks_out;
  } result_t;

endpackage

`default_nettype wire

/* rtl/chunked_image_reassembly.sv */
// Latency: the results of an accepted byte enter the result queue at the accepting edge
// and are offered on the output from the next cycle if the queue held no older results.
// Throughput: one byte per cycle; a byte causes at most two results, and in_ready drops
// while the four-entry result queue holds more than two results.
// Reset (rst, synchronous): clears packet and image state, the chunk bitmap and the queue,
// and sets chunk_bytes to 200.
// top level of the chunked image reassembly block
// depends on cir_pkg
`default_nettype none

module chunked_image_reassembly
  import cir_pkg::*;
#(
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEFAULT,
  parameter int IMAGE_BYTES = IMAGE_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write_en,
  input  wire logic [7:0]  cfg_write_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_packet,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic [11:0]      write_addr,
  output logic [7:0]       write_data,
  output logic [15:0]      mean_delta,
  output logic [7:0]       peak_delta,
  output logic [15:0]      changed_count,
  output logic [7:0]       grey_level,
  output logic             sent_flag,
  output logic [7:0]       total_chunks_out
);

  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int QP_W  = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [16:0] MAX_CHUNKS_V  = 17'(MAX_CHUNKS);
  localparam logic [16:0] IMAGE_BYTES_V = 17'(IMAGE_BYTES);
  localparam logic [QC_W-1:0] QUEUE_ROOM = QC_W'(QUEUE_DEPTH - 2);

  // state
  logic [7:0]            chunk_bytes;
  logic [7:0]            byte_position, byte_position_next;
  logic [7:0]            packet_kind, packet_kind_next;
  logic [15:0]           header_chunk, header_chunk_next;
  logic [7:0]            header_total_lo, header_total_lo_next;
  logic [MAX_CHUNKS-1:0] chunk_seen, chunk_seen_next;
  logic [7:0]            image_total, image_total_next;
  logic [7:0]            chunks_counted, chunks_counted_next;
  logic                  image_active, image_active_next;
  logic                  payload_enable, payload_enable_next;
  logic                  complete_pending, complete_pending_next;
  logic [15:0]           write_pointer, write_pointer_next;
  logic [7:0]            metadata_bytes [6];
  logic                  meta_we;
  logic [2:0]            meta_idx;

  // result queue
  result_t               queue [QUEUE_DEPTH];
  logic [QP_W-1:0]       rd_ptr, wr_ptr;
  logic [QC_W-1:0]       count;

  logic    accept, pop;
  logic    first_valid, cplt_valid;
  result_t first_res, cplt_res;

  // header decision signals
  logic [15:0] total_full;
  logic        total_ok, restart, in_range, seen_bit, take_chunk;
  logic [7:0]  count_base, count_new, total_new;
  logic [23:0] offset_prod;
  logic [IDX_W-1:0] chunk_idx;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= QUEUE_ROOM);

  // header decision on the high total byte
  always_comb begin
    total_full  = {data_byte, header_total_lo};
    total_ok    = (total_full <= {8'd0, TOTAL_LIMIT});
    restart     = !image_active || (total_full != {8'd0, image_total});
    in_range    = ({1'b0, header_chunk} < MAX_CHUNKS_V);
    chunk_idx   = header_chunk[IDX_W-1:0];
    seen_bit    = restart ? 1'b0 : chunk_seen[chunk_idx];
    take_chunk  = in_range && !seen_bit;
    count_base  = restart ? 8'd0 : chunks_counted;
    count_new   = (take_chunk && count_base != 8'hFF) ? count_base + 8'd1 : count_base;
    total_new   = restart ? total_full[7:0] : image_total;
    offset_prod = header_chunk * {8'd0, chunk_bytes};
  end

  // per-byte update and result formation
  always_comb begin
    byte_position_next    = byte_position;
    packet_kind_next      = packet_kind;
    header_chunk_next     = header_chunk;
    header_total_lo_next  = header_total_lo;
    chunk_seen_next       = chunk_seen;
    image_total_next      = image_total;
    chunks_counted_next   = chunks_counted;
    image_active_next     = image_active;
    payload_enable_next   = payload_enable;
    complete_pending_next = complete_pending;
    write_pointer_next    = write_pointer;
    meta_we               = 1'b0;
    meta_idx              = 3'(byte_position - 8'd1);
    first_valid           = 1'b0;
    first_res             = '0;
    cplt_valid            = 1'b0;
    cplt_res              = '0;

    if (byte_position == 8'd0) begin
      packet_kind_next = data_byte;
    end else if (packet_kind == KIND_IMAGE && byte_position < HEADER_LEN) begin
      case (byte_position)
        POS_CHUNK_LO: header_chunk_next[7:0]  = data_byte;
        POS_CHUNK_HI: header_chunk_next[15:8] = data_byte;
        POS_TOTAL_LO: header_total_lo_next    = data_byte;
        default: begin
          // take the header: restart, mark the chunk, check completion
          if (total_ok) begin
            if (restart) begin
              chunk_seen_next = '0;
            end
            if (take_chunk) begin
              chunk_seen_next[chunk_idx] = 1'b1;
              payload_enable_next        = 1'b1;
              write_pointer_next = (offset_prod > 24'h00FFFF) ? 16'hFFFF : offset_prod[15:0];
            end
            image_total_next    = total_new;
            chunks_counted_next = count_new;
            if (count_new == total_new) begin
              complete_pending_next = 1'b1;
              image_active_next     = 1'b0;
            end else begin
              image_active_next = 1'b1;
            end
          end
        end
      endcase
    end else if (packet_kind == KIND_IMAGE && payload_enable) begin
      // payload byte write
      if ({1'b0, write_pointer} < IMAGE_BYTES_V) begin
        first_valid          = 1'b1;
        first_res.event_kind = EV_WRITE;
        first_res.write_addr = write_pointer[11:0];
        first_res.write_data = data_byte;
      end
      if (write_pointer != 16'hFFFF) begin
        write_pointer_next = write_pointer + 16'd1;
      end
    end else if (packet_kind == KIND_META && byte_position < META_LEN - 8'd1) begin
      meta_we = 1'b1;
    end else if (packet_kind == KIND_META && byte_position == META_LEN - 8'd1 &&
                 end_of_packet) begin
      // metadata record
      first_valid             = 1'b1;
      first_res.event_kind    = EV_META;
      first_res.mean_delta    = {metadata_bytes[1], metadata_bytes[0]};
      first_res.peak_delta    = metadata_bytes[2];
      first_res.changed_count = {metadata_bytes[4], metadata_bytes[3]};
      first_res.grey_level    = metadata_bytes[5];
      first_res.sent_flag     = (data_byte != 8'd0);
    end

    // end of packet: completion event and packet reset
    if (end_of_packet) begin
      if (complete_pending_next) begin
        cplt_valid                = 1'b1;
        cplt_res.event_kind       = EV_COMPLETE;
        cplt_res.total_chunks_out = image_total_next;
      end
      complete_pending_next = 1'b0;
      payload_enable_next   = 1'b0;
      byte_position_next    = 8'd0;
    end else if (byte_position != 8'hFF) begin
      byte_position_next = byte_position + 8'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes      <= CHUNK_BYTES_RESET;
      byte_position    <= '0;
      packet_kind      <= '0;
      header_chunk     <= '0;
      header_total_lo  <= '0;
      chunk_seen       <= '0;
      image_total      <= '0;
      chunks_counted   <= '0;
      image_active     <= 1'b0;
      payload_enable   <= 1'b0;
      complete_pending <= 1'b0;
      write_pointer    <= '0;
    end else begin
      if (cfg_write_en) begin
        chunk_bytes <= cfg_write_data;
      end
      if (accept) begin
        byte_position    <= byte_position_next;
        packet_kind      <= packet_kind_next;
        header_chunk     <= header_chunk_next;
        header_total_lo  <= header_total_lo_next;
        chunk_seen       <= chunk_seen_next;
        image_total      <= image_total_next;
        chunks_counted   <= chunks_counted_next;
        image_active     <= image_active_next;
        payload_enable   <= payload_enable_next;
        complete_pending <= complete_pending_next;
        write_pointer    <= write_pointer_next;
      end
    end
  end

  // metadata bytes 1 to 6
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        metadata_bytes[i] <= '0;
      end
    end else if (accept && meta_we) begin
      metadata_bytes[meta_idx] <= data_byte;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + QP_W'(1);
      end
      if (accept) begin
        wr_ptr <= wr_ptr + QP_W'(first_valid) + QP_W'(cplt_valid);
      end
      count <= count + (accept ? QC_W'(first_valid) + QC_W'(cplt_valid) : QC_W'(0))
                     - QC_W'(pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (accept && first_valid) begin
      queue[wr_ptr] <= first_res;
    end
    if (accept && cplt_valid) begin
      queue[wr_ptr + QP_W'(first_valid)] <= cplt_res;
    end
  end

  // output channel
  assign out_valid        = (count != '0);
  assign event_kind       = queue[rd_ptr].event_kind;
  assign write_addr       = queue[rd_ptr].write_addr;
  assign write_data       = queue[rd_ptr].write_data;
  assign mean_delta       = queue[rd_ptr].mean_delta;
  assign peak_delta       = queue[rd_ptr].peak_delta;
  assign changed_count    = queue[rd_ptr].changed_count;
  assign grey_level       = queue[rd_ptr].grey_level;
  assign sent_flag        = queue[rd_ptr].sent_flag;
  assign total_chunks_out = queue[rd_ptr].total_chunks_out;

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // packet position restarts after a last byte
  a_packet_restart: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_packet |=> byte_position == 8'd0)
    else $error("byte position not cleared after end of packet");

  // payload writes only inside an image packet
  a_payload_kind: assert property (@(posedge clk) disable iff (rst)
    payload_enable |-> packet_kind == KIND_IMAGE)
    else $error("payload enabled outside an image packet");

  // a completed image never reports a total above the limit
  a_complete_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_COMPLETE |-> total_chunks_out <= TOTAL_LIMIT)
    else $error("complete event with total out of range");

  // no completion pending after the last byte of a packet
  a_pending_clear: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_packet |=> !complete_pending && !payload_enable)
    else $error("packet flags survive end of packet");
`endif

endmodule

`default_nettype wire

/* tb/tb_chunked_image_reassembly.sv */
`timescale 1ns / 1ps
// self-checking testbench for chunked_image_reassembly: directed packet table, then random
// packet traffic in phases with idling, stalls and a long output hold-off
// depends on cir_pkg and the chunked_image_reassembly top level

module tb_chunked_image_reassembly
  import cir_pkg::*;
();

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 320;

  // kinds of table row
  typedef enum logic [1:0] {
    ROW_CFG,   // register write, value holds chunk_bytes
    ROW_MODEL, // byte, results come from the predictor
    ROW_NONE,  // byte, no result allowed
    ROW_ONE    // byte, exactly the typed result
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    logic       eop;
    result_t    typed_ev;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_en;
  logic [7:0]  cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_packet;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  event_kind;
  logic [11:0] write_addr;
  logic [7:0]  write_data;
  logic [15:0] mean_delta;
  logic [7:0]  peak_delta;
  logic [15:0] changed_count;
  logic [7:0]  grey_level;
  logic        sent_flag;
  logic [7:0]  total_chunks_out;

  chunked_image_reassembly u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .end_of_packet    (end_of_packet),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .event_kind       (event_kind),
    .write_addr       (write_addr),
    .write_data       (write_data),
    .mean_delta       (mean_delta),
    .peak_delta       (peak_delta),
    .changed_count    (changed_count),
    .grey_level       (grey_level),
    .sent_flag        (sent_flag),
    .total_chunks_out (total_chunks_out)
  );

  always #HALF_PERIOD clk = ~clk;

  // predictor copy of the block state, at reset values
  logic [7:0]                     chunk_bytes = CHUNK_BYTES_RESET;
  logic [7:0]                     pkt_pos     = '0;
  logic [7:0]                     pkt_kind    = '0;
  logic [15:0]                    hdr_chunk   = '0;
  logic [15:0]                    hdr_total   = '0;
  logic [MAX_CHUNKS_DEFAULT-1:0]  seen_map    = '0;
  logic [7:0]                     img_total   = '0;
  logic [7:0]                     counted     = '0;
  logic                           img_active  = 1'b0;
  logic                           writing     = 1'b0;
  logic                           done_due    = 1'b0;
  logic [15:0]                    wr_ptr      = '0;
  logic [5:0][7:0]                meta_bytes  = '0;

  result_t   step_events[$];
  result_t   due_events[$];
  stim_row_t stim_rows[$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  bit          hold_request       = 1'b0;
  int unsigned fail_count         = 0;
  int unsigned items_sent         = 0;
  int unsigned results_checked    = 0;
  int unsigned writes_seen        = 0;
  int unsigned meta_seen          = 0;
  int unsigned completes_seen     = 0;
  int unsigned settings_used      = 0;
  int unsigned session_total      = 0;
  int unsigned session_left       = 0;
  int unsigned idle_cycles        = 0;

  function automatic result_t meta_event(input logic [15:0] mean, input logic [7:0] peak,
                                         input logic [15:0] changed, input logic [7:0] grey,
                                         input logic sent);
    result_t ev;
    ev               = '0;
    ev.event_kind    = EV_META;
    ev.mean_delta    = mean;
    ev.peak_delta    = peak;
    ev.changed_count = changed;
    ev.grey_level    = grey;
    ev.sent_flag     = sent;
    return ev;
  endfunction

  function automatic result_t complete_event(input logic [7:0] total);
    result_t ev;
    ev                  = '0;
    ev.event_kind       = EV_COMPLETE;
    ev.total_chunks_out = total;
    return ev;
  endfunction

  // reassembly predictor: one packet byte in, its events into step_events
  function automatic void reassemble_step(input logic [7:0] b, input logic eop);
    result_t     ev;
    int unsigned offset;
    step_events.delete();
    if (pkt_pos == 8'd0) begin
      pkt_kind = b;
    end else if (pkt_kind == KIND_IMAGE && pkt_pos < HEADER_LEN) begin
      case (pkt_pos)
        POS_CHUNK_LO: hdr_chunk[7:0] = b;
        POS_CHUNK_HI: hdr_chunk[15:8] = b;
        POS_TOTAL_LO: hdr_total[7:0] = b;
        default: begin
          // header complete: restart, count and place the chunk
          hdr_total[15:8] = b;
          if (hdr_total <= 16'(TOTAL_LIMIT)) begin
            if (!img_active || hdr_total != 16'(img_total)) begin
              seen_map   = '0;
              img_total  = hdr_total[7:0];
              counted    = '0;
              img_active = 1'b1;
            end
            if (hdr_chunk < 16'(MAX_CHUNKS_DEFAULT) && !seen_map[hdr_chunk[6:0]]) begin
              seen_map[hdr_chunk[6:0]] = 1'b1;
              if (counted != 8'hFF) counted = counted + 8'd1;
              writing = 1'b1;
              offset  = 32'(hdr_chunk) * 32'(chunk_bytes);
              wr_ptr  = (offset > 32'hFFFF) ? 16'hFFFF : offset[15:0];
            end
            if (counted == img_total) begin
              done_due   = 1'b1;
              img_active = 1'b0;
            end
          end
        end
      endcase
    end else if (pkt_kind == KIND_IMAGE && writing) begin
      // payload byte, dropped past the end of the buffer
      if (wr_ptr < 16'(IMAGE_BYTES_DEFAULT)) begin
        ev            = '0;
        ev.event_kind = EV_WRITE;
        ev.write_addr = wr_ptr[11:0];
        ev.write_data = b;
        step_events.push_back(ev);
      end
      if (wr_ptr != 16'hFFFF) wr_ptr = wr_ptr + 16'd1;
    end else if (pkt_kind == KIND_META && pkt_pos < META_LEN - 8'd1) begin
      meta_bytes[3'(pkt_pos - 8'd1)] = b;
    end else if (pkt_kind == KIND_META && pkt_pos == META_LEN - 8'd1 && eop) begin
      step_events.push_back(meta_event({meta_bytes[1], meta_bytes[0]}, meta_bytes[2],
                                       {meta_bytes[4], meta_bytes[3]}, meta_bytes[5],
                                       b != 8'h00));
    end
    // end of packet: completion and position restart
    if (eop) begin
      if (done_due) step_events.push_back(complete_event(img_total));
      done_due = 1'b0;
      writing  = 1'b0;
      pkt_pos  = 8'd0;
    end else if (pkt_pos != 8'hFF) begin
      pkt_pos = pkt_pos + 8'd1;
    end
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [7:0] value,
                                  input logic eop, input result_t typed_ev);
    stim_row_t row;
    row.kind     = kind;
    row.value    = value;
    row.eop      = eop;
    row.typed_ev = typed_ev;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_image_packet(input logic [15:0] idx, input logic [15:0] total,
                                           input int unsigned payload_len);
    add_row(ROW_MODEL, KIND_IMAGE, 1'b0, '0);
    add_row(ROW_MODEL, idx[7:0], 1'b0, '0);
    add_row(ROW_MODEL, idx[15:8], 1'b0, '0);
    add_row(ROW_MODEL, total[7:0], 1'b0, '0);
    add_row(ROW_MODEL, total[15:8], payload_len == 0, '0);
    for (int unsigned i = 1; i <= payload_len; i++)
      add_row(ROW_MODEL, 8'($urandom), i == payload_len, '0);
  endfunction

  // one random packet: mostly well-formed image chunks and metadata, some broken ones
  function automatic void queue_random_packet();
    int unsigned pick;
    int unsigned roll;
    int unsigned len;
    logic [15:0] idx;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // well-formed metadata
      add_row(ROW_MODEL, KIND_META, 1'b0, '0);
      for (int i = 1; i < 7; i++) add_row(ROW_MODEL, 8'($urandom), 1'b0, '0);
      add_row(ROW_MODEL, ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom), 1'b1, '0);
    end else if (pick < 75) begin
      // chunk of the current image; a new total starts a new image
      if (session_left == 0) begin
        roll = $urandom_range(99);
        if (roll < 5)       session_total = 0;
        else if (roll < 70) session_total = $urandom_range(1, 6);
        else if (roll < 90) session_total = $urandom_range(7, 40);
        else                session_total = $urandom_range(41, 128);
        session_left = (session_total < 8) ? session_total + $urandom_range(1, 3)
                                           : $urandom_range(4, 12);
      end
      session_left--;
      roll = $urandom_range(99);
      if (roll < 8 || session_total == 0)
        idx = ($urandom_range(1) == 1) ? 16'($urandom_range(128, 65535))
                                       : 16'($urandom_range(0, 127));
      else if (roll < 12)
        idx = 16'd127;
      else
        idx = 16'($urandom_range(0, session_total - 1));
      roll = $urandom_range(99);
      if (roll < 80)      len = $urandom_range(0, 8);
      else if (roll < 97) len = $urandom_range(9, 40);
      else                len = $urandom_range(240, 300);
      add_image_packet(idx, 16'(session_total), len);
    end else if (pick < 83) begin
      if ($urandom_range(1) == 1) begin
        // total above the limit
        add_image_packet(16'($urandom), 16'($urandom_range(129, 65535)),
                         $urandom_range(0, 4));
      end else begin
        // image packet cut inside the header
        len = $urandom_range(1, 4);
        add_row(ROW_MODEL, KIND_IMAGE, len == 1, '0);
        for (int unsigned i = 2; i <= len; i++)
          add_row(ROW_MODEL, 8'($urandom), i == len, '0);
      end
    end else if (pick < 93) begin
      // metadata of the wrong length, now and then long enough to saturate the position
      roll = $urandom_range(99);
      if (roll < 45)      len = $urandom_range(1, 7);
      else if (roll < 95) len = $urandom_range(9, 16);
      else                len = $urandom_range(256, 280);
      add_row(ROW_MODEL, KIND_META, len == 1, '0);
      for (int unsigned i = 2; i <= len; i++)
        add_row(ROW_MODEL, 8'($urandom), i == len, '0);
    end else begin
      // any type byte, any short length
      len = $urandom_range(1, 8);
      for (int unsigned i = 1; i <= len; i++)
        add_row(ROW_MODEL, 8'($urandom), i == len, '0);
    end
  endfunction

  // offer one byte from a falling edge; returns at the rising edge of the transaction
  task automatic send_byte(input logic [7:0] b, input logic eop);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_packet <= eop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // register write once the block has gone quiet
  task automatic set_chunk_bytes(input logic [7:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    chunk_bytes  = value;
    settings_used++;
  endtask

  task automatic run_rows();
    stim_row_t row;
    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      if (row.kind == ROW_CFG) begin
        set_chunk_bytes(row.value);
      end else begin
        send_byte(row.value, row.eop);
        reassemble_step(row.value, row.eop);
        items_sent++;
        if (row.kind == ROW_MODEL)
          foreach (step_events[i]) due_events.push_back(step_events[i]);
        else if (row.kind == ROW_ONE)
          due_events.push_back(row.typed_ev);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit hold_served;
    hold_served = 1'b0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // compare every result transaction with the oldest expected event
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        $error("result with nothing expected: event_kind %0d", event_kind);
        fail_count++;
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", 16'(want.event_kind), 16'(event_kind));
        check_field("write_addr", 16'(want.write_addr), 16'(write_addr));
        check_field("write_data", 16'(want.write_data), 16'(write_data));
        check_field("mean_delta", want.mean_delta, mean_delta);
        check_field("peak_delta", 16'(want.peak_delta), 16'(peak_delta));
        check_field("changed_count", want.changed_count, changed_count);
        check_field("grey_level", 16'(want.grey_level), 16'(grey_level));
        check_field("sent_flag", 16'(want.sent_flag), 16'(sent_flag));
        check_field("total_chunks_out", 16'(want.total_chunks_out), 16'(total_chunks_out));
        results_checked++;
        case (want.event_kind)
          EV_WRITE: writes_seen++;
          EV_META:  meta_seen++;
          default:  completes_seen++;
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    data_byte      = '0;
    end_of_packet  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // metadata record with every field away from zero
    add_row(ROW_MODEL, KIND_META, 1'b0, '0);
    add_row(ROW_MODEL, 8'h34, 1'b0, '0);
    add_row(ROW_MODEL, 8'h12, 1'b0, '0);
    add_row(ROW_MODEL, 8'hFF, 1'b0, '0);
    add_row(ROW_MODEL, 8'hCD, 1'b0, '0);
    add_row(ROW_MODEL, 8'hAB, 1'b0, '0);
    add_row(ROW_MODEL, 8'h80, 1'b0, '0);
    add_row(ROW_ONE, 8'h01, 1'b1, meta_event(16'h1234, 8'hFF, 16'hABCD, 8'h80, 1'b1));
    // unknown type byte, one-byte packet
    add_row(ROW_NONE, 8'hFF, 1'b1, '0);
    // zero chunk size: chunk 5 of 2 lands at address 0, payload runs past the chunk
    add_row(ROW_CFG, 8'd0, 1'b0, '0);
    add_row(ROW_MODEL, KIND_IMAGE, 1'b0, '0);
    add_row(ROW_MODEL, 8'h05, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_MODEL, 8'h02, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_MODEL, 8'hAA, 1'b0, '0);
    add_row(ROW_MODEL, 8'h55, 1'b1, '0);
    // largest chunk size: chunk 10 lands past the buffer, write dropped, image complete
    add_row(ROW_CFG, 8'd255, 1'b0, '0);
    add_row(ROW_MODEL, KIND_IMAGE, 1'b0, '0);
    add_row(ROW_MODEL, 8'h0A, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_MODEL, 8'h02, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_ONE, 8'h7E, 1'b1, complete_event(8'd2));
    // total above the limit: packet ignored
    add_row(ROW_MODEL, KIND_IMAGE, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_MODEL, 8'hFF, 1'b0, '0);
    add_row(ROW_NONE, 8'hFF, 1'b1, '0);
    // zero total with an out-of-range index completes at once
    add_row(ROW_MODEL, KIND_IMAGE, 1'b0, '0);
    add_row(ROW_MODEL, 8'hC8, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_MODEL, 8'h00, 1'b0, '0);
    add_row(ROW_ONE, 8'h00, 1'b1, complete_event(8'd0));
    run_rows();

    // random phases, each with its own chunk size and idling pattern
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_chunk_bytes(8'd1);
        1: set_chunk_bytes(8'd245);
        2: set_chunk_bytes(8'd0);
        3: set_chunk_bytes(8'd255);
        4: set_chunk_bytes(8'($urandom_range(2, 244)));
        default: set_chunk_bytes(CHUNK_BYTES_RESET);
      endcase
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      // output held off while bytes keep coming, so the result queue fills
      if (phase == 4) hold_request = 1'b1;
      for (int unsigned target = items_sent + ITEMS_PER_PHASE; items_sent < target; ) begin
        queue_random_packet();
        run_rows();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d packet bytes over %0d chunk size settings, checked %0d results",
             items_sent, settings_used, results_checked);
    $display("  %0d buffer writes, %0d metadata records, %0d completed images",
             writes_seen, meta_seen, completes_seen);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/cir_pkg.sv
rtl/chunked_image_reassembly.sv
tb/tb_chunked_image_reassembly.sv
